// ===== hdl/websocket_frame_deframer_top_macros.svh =====
// Assertion macros shared by the websocket frame deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define WSFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition on one edge implies a consequence on the same edge.
`define WSFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/wsfd_pkg.sv =====
// Types and constants of the websocket frame deframer.
package wsfd_pkg;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned KIND_W     = 2;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [7:0] BYTE_MASK = 8'hFF;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef enum logic [1:0] {
    KIND_HDR = 2'd0,
    KIND_PAY = 2'd1,
    KIND_ERR = 2'd2
  } kind_t;

  typedef enum logic {
    ERR_SHORT  = 1'b0,
    ERR_OPCODE = 1'b1
  } err_code_t;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT   = 3'd2,
    PH_KEY   = 3'd3,
    PH_PAY   = 3'd4,
    PH_DRAIN = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       op_ok;
    logic       len16;
    logic       len64;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic       final_fragment;
    logic [2:0] reserved_bits;
    logic [3:0] frame_opcode;
    logic       masked;
    logic [63:0] length;
    logic       frame_done;
    err_code_t  error_code;
  } result_t;

  function automatic logic opcode_ok(input logic [3:0] op);
    case (op)
      4'd0, 4'd1, 4'd2, 4'd8, 4'd9, 4'd10: opcode_ok = 1'b1;
      default: opcode_ok = 1'b0;
    endcase
  endfunction

endpackage

// ===== hdl/wsfd_front.sv =====
// Input side: accepts bytes and tags them with their header classification.
module wsfd_front (
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [wsfd_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                         in_tlast,
  input  wsfd_pkg::q_status_t          q_status,
  output logic                         q_push,
  output wsfd_pkg::q_entry_t           q_wdata
);
  import wsfd_pkg::*;

  logic [6:0] len7;

  assign len7      = in_tdata[6:0];
  assign in_tready = !q_status.full;
  assign q_push    = in_tvalid && !q_status.full;

  always_comb begin
    q_wdata.data_byte = in_tdata[7:0];
    q_wdata.last      = in_tlast;
    q_wdata.op_ok     = opcode_ok(in_tdata[3:0]);
    q_wdata.len16     = (len7 == LEN_EXT16);
    q_wdata.len64     = (len7 == LEN_EXT64);
  end

endmodule

// ===== hdl/wsfd_queue.sv =====
// Short queue of classified words between the input side and the parser.
module wsfd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  wsfd_pkg::q_entry_t   wdata,
  input  logic                 pop,
  output wsfd_pkg::q_entry_t   rdata,
  output wsfd_pkg::q_status_t  status
);
  import wsfd_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign rdata        = mem_r[rd_ptr_r];
  assign status.full  = (count_r == CNT_FULL);
  assign status.valid = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/wsfd_back.sv =====
// Frame parser: header state machine, unmasking and the result register.
module wsfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  wsfd_pkg::q_status_t q_status,
  input  wsfd_pkg::q_entry_t  q_rdata,
  output logic                q_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output wsfd_pkg::result_t   res
);
  import wsfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic        mask_r, mask_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] key_r, key_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [1:0]  midx_r, midx_nxt;
  logic        bad_r, bad_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res_nxt;

  logic        last;
  logic [7:0]  b;
  logic        emit_err;
  err_code_t   err_code;
  logic        emit_frame;
  kind_t       frame_kind;
  logic [7:0]  frame_byte;
  logic        frame_done;
  logic        after_len;
  logic        hdr_complete;
  logic [7:0]  key_byte;

  assign q_pop     = q_status.valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = res_r;
  assign b         = q_rdata.data_byte;
  assign last      = q_rdata.last;

  always_comb begin
    case (midx_r)
      2'd0: key_byte = key_r[31:24];
      2'd1: key_byte = key_r[23:16];
      2'd2: key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    hdr_nxt      = hdr_r;
    mask_nxt     = mask_r;
    len_nxt      = len_r;
    key_nxt      = key_r;
    rem_nxt      = rem_r;
    midx_nxt     = midx_r;
    bad_nxt      = bad_r;
    emit_err     = 1'b0;
    err_code     = ERR_SHORT;
    emit_frame   = 1'b0;
    frame_kind   = KIND_HDR;
    frame_byte   = '0;
    frame_done   = 1'b0;
    after_len    = 1'b0;
    hdr_complete = 1'b0;

    if (q_pop) begin
      case (phase_r)
        PH_HDR0: begin
          hdr_nxt   = b;
          mask_nxt  = 1'b0;
          len_nxt   = '0;
          key_nxt   = '0;
          rem_nxt   = '0;
          midx_nxt  = '0;
          cnt_nxt   = '0;
          bad_nxt   = !q_rdata.op_ok;
          if (last) begin
            emit_err  = 1'b1;
            phase_nxt = PH_HDR0;
          end else begin
            phase_nxt = PH_HDR1;
          end
        end
        PH_HDR1: begin
          if (bad_r) begin
            emit_err  = 1'b1;
            err_code  = ERR_OPCODE;
            phase_nxt = last ? PH_HDR0 : PH_DRAIN;
          end else begin
            mask_nxt = b[7];
            if (q_rdata.len16 || q_rdata.len64) begin
              if (last) begin
                emit_err  = 1'b1;
                phase_nxt = PH_HDR0;
              end else begin
                cnt_nxt   = q_rdata.len16 ? EXT16_BYTES : EXT64_BYTES;
                len_nxt   = '0;
                phase_nxt = PH_EXT;
              end
            end else begin
              len_nxt   = {57'd0, b[6:0]};
              after_len = 1'b1;
            end
          end
        end
        PH_EXT: begin
          len_nxt = {len_r[55:0], b};
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_nxt != '0) begin
            if (last) begin
              emit_err  = 1'b1;
              phase_nxt = PH_HDR0;
            end
          end else begin
            after_len = 1'b1;
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], b};
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_nxt != '0) begin
            if (last) begin
              emit_err  = 1'b1;
              phase_nxt = PH_HDR0;
            end
          end else begin
            hdr_complete = 1'b1;
          end
        end
        PH_PAY: begin
          rem_nxt = rem_r - 1'b1;
          if ((rem_r != 64'd1) && last) begin
            emit_err  = 1'b1;
            phase_nxt = PH_HDR0;
          end else begin
            midx_nxt   = midx_r + 1'b1;
            emit_frame = 1'b1;
            frame_kind = KIND_PAY;
            frame_byte = (b ^ key_byte) & BYTE_MASK;
            frame_done = (rem_r == 64'd1);
            if (rem_r == 64'd1) begin
              phase_nxt = last ? PH_HDR0 : PH_DRAIN;
            end
          end
        end
        PH_DRAIN: begin
          if (last) begin
            phase_nxt = PH_HDR0;
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
        end
      endcase

      if (after_len) begin
        if (mask_nxt) begin
          if (last) begin
            emit_err  = 1'b1;
            phase_nxt = PH_HDR0;
          end else begin
            cnt_nxt   = KEY_BYTES;
            phase_nxt = PH_KEY;
          end
        end else begin
          hdr_complete = 1'b1;
        end
      end

      if (hdr_complete) begin
        if (len_nxt == '0) begin
          phase_nxt  = last ? PH_HDR0 : PH_DRAIN;
          emit_frame = 1'b1;
          frame_done = 1'b1;
        end else if (last) begin
          emit_err  = 1'b1;
          phase_nxt = PH_HDR0;
        end else begin
          rem_nxt    = len_nxt;
          midx_nxt   = '0;
          phase_nxt  = PH_PAY;
          emit_frame = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_err) begin
      out_valid_nxt      = 1'b1;
      res_nxt            = '0;
      res_nxt.kind       = KIND_ERR;
      res_nxt.error_code = err_code;
    end else if (emit_frame) begin
      out_valid_nxt          = 1'b1;
      res_nxt.kind           = frame_kind;
      res_nxt.payload_byte   = frame_byte;
      res_nxt.final_fragment = hdr_nxt[7];
      res_nxt.reserved_bits  = hdr_nxt[6:4];
      res_nxt.frame_opcode   = hdr_nxt[3:0];
      res_nxt.masked         = mask_nxt;
      res_nxt.length         = len_nxt;
      res_nxt.frame_done     = frame_done;
      res_nxt.error_code     = ERR_SHORT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR0;
      cnt_r       <= '0;
      hdr_r       <= '0;
      mask_r      <= 1'b0;
      len_r       <= '0;
      key_r       <= '0;
      rem_r       <= '0;
      midx_r      <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      hdr_r       <= hdr_nxt;
      mask_r      <= mask_nxt;
      len_r       <= len_nxt;
      key_r       <= key_nxt;
      rem_r       <= rem_nxt;
      midx_r      <= midx_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// ===== hdl/websocket_frame_deframer_top.sv =====
// Top level of the websocket frame deframer.
// The input stream carries one frame-buffer byte per word in in_tdata[7:0];
// in_tlast marks the last byte of the buffer, and the next word starts a new frame.
// The output stream carries at most one result per input word: a header word,
// a payload word with the unmasked byte, or an error word, with the kind in out_tuser.
// out_tlast is set on the header word of an empty frame and on the last payload word.
// Bytes after the end of a frame are dropped up to the buffer's last byte.
// An accepted word is written into the input queue, and its result is registered in the result register.
// The block takes one word per cycle while the queue is not full; a single pass of the parser state
// machine per word sets that figure, and the small input queue holds words while the output stalls.
// Payload words can leave before a short-frame error for the same buffer.
// When out_tready is low, the result register holds its word and the queue fills;
// in_tready drops only when the queue is full.
// Reset is synchronous and active low; it empties the queue and the result register
// and sets the parser to wait for the first header byte.
module websocket_frame_deframer_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [wsfd_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [wsfd_pkg::OUT_DATA_W-1:0] out_tdata,  // [7:0] payload_byte, [8] final_fragment,
                                                      // [11:9] reserved_bits, [15:12] frame_opcode,
                                                      // [16] masked, [80:17] length,
                                                      // [81] error_code, [87:82] zero
  output logic [wsfd_pkg::KIND_W-1:0]     out_tuser,  // [1:0] kind
  output logic                            out_tlast
);
  import wsfd_pkg::*;

  `include "websocket_frame_deframer_top_macros.svh"

  q_status_t q_status;
  q_entry_t  q_wdata;
  q_entry_t  q_rdata;
  logic      q_push;
  logic      q_pop;
  result_t   res;

  wsfd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  wsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  wsfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tuser = res.kind;
  assign out_tlast = res.frame_done;
  assign out_tdata = {6'd0, res.error_code, res.length, res.masked, res.frame_opcode,
                      res.reserved_bits, res.final_fragment, res.payload_byte};

  `WSFD_ASSERT_IMP(a_err_clean, out_tvalid && (out_tuser == KIND_ERR),
    !out_tlast && (out_tdata[80:0] == '0), "error word carries header fields")
  `WSFD_ASSERT_IMP(a_pay_len, out_tvalid && (out_tuser == KIND_PAY),
    out_tdata[80:17] != '0, "payload word with zero frame length")
  `WSFD_ASSERT_IMP(a_hdr_done, out_tvalid && (out_tuser == KIND_HDR) && out_tlast,
    out_tdata[80:17] == '0, "header word ends a frame with nonzero length")
  `WSFD_ASSERT_IMP(a_pop_valid, q_pop, q_status.valid, "parser read an empty queue")

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the websocket frame deframer with a byte-level frame predictor.
module tb;
  import wsfd_pkg::*;

  localparam logic [3:0] OP_CONT        = 4'd0;
  localparam logic [3:0] OP_TEXT        = 4'd1;
  localparam logic [3:0] OP_BINARY      = 4'd2;
  localparam logic [3:0] OP_CLOSE       = 4'd8;
  localparam logic [3:0] OP_PING        = 4'd9;
  localparam logic [3:0] OP_PONG        = 4'd10;
  localparam logic [3:0] OP_RESERVED_LO = 4'd3;
  localparam logic [3:0] OP_RESERVED_HI = 4'd15;

  localparam int NO_CUT       = -1;
  localparam int ANY_CUT      = -2;
  localparam int RANDOM_ITEMS = 1850;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_SLACK  = 8;
  localparam int END_WAIT     = 5000;

  typedef enum int {FORM_7BIT, FORM_16BIT, FORM_64BIT} len_form_t;
  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  payload;
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] length;
    logic        done;
    err_code_t   err;
  } frame_word_t;

  function automatic logic opcode_valid(logic [3:0] op);
    case (op)
      OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  class frame_scoreboard;
    phase_t      phase;
    logic [3:0]  field_count;
    logic [7:0]  first_header;
    logic        mask_flag;
    logic [63:0] length_reg;
    logic [31:0] unmask_key;
    logic [63:0] remaining;
    logic [1:0]  mask_index;
    logic        bad_opcode;
    frame_word_t pending_results[$];
    int          failures;
    int          useful_bytes;

    function new();
      phase = PH_HDR0;
      field_count = '0;
      first_header = '0;
      mask_flag = 1'b0;
      length_reg = '0;
      unmask_key = '0;
      remaining = '0;
      mask_index = '0;
      bad_opcode = 1'b0;
      failures = 0;
      useful_bytes = 0;
    endfunction

    function void push_error(err_code_t code);
      frame_word_t w;
      w.kind = KIND_ERR;
      w.payload = '0;
      w.fin = 1'b0;
      w.rsv = '0;
      w.opcode = '0;
      w.masked = 1'b0;
      w.length = '0;
      w.done = 1'b0;
      w.err = code;
      pending_results.insert(pending_results.size(), w);
    endfunction

    function void push_frame(kind_t kind, logic [7:0] data, logic done);
      frame_word_t w;
      w.kind = kind;
      w.payload = data;
      w.fin = first_header[7];
      w.rsv = first_header[6:4];
      w.opcode = first_header[3:0];
      w.masked = mask_flag;
      w.length = length_reg;
      w.done = done;
      w.err = ERR_SHORT;
      pending_results.insert(pending_results.size(), w);
    endfunction

    function void short_frame();
      phase = PH_HDR0;
      push_error(ERR_SHORT);
    endfunction

    function void header_done(logic last);
      if (length_reg == 64'd0) begin
        phase = last ? PH_HDR0 : PH_DRAIN;
        push_frame(KIND_HDR, 8'd0, 1'b1);
      end else if (last) begin
        short_frame();
      end else begin
        remaining = length_reg;
        mask_index = '0;
        phase = PH_PAY;
        push_frame(KIND_HDR, 8'd0, 1'b0);
      end
    endfunction

    function void length_done(logic last);
      if (mask_flag) begin
        if (last) begin
          short_frame();
        end else begin
          field_count = KEY_BYTES;
          phase = PH_KEY;
        end
      end else begin
        header_done(last);
      end
    endfunction

    function void parse_byte(logic [7:0] b, logic last);
      logic [6:0] len7;
      logic [7:0] kb;
      logic       done;
      int         sh;
      if (phase != PH_DRAIN) useful_bytes++;
      case (phase)
        PH_HDR0: begin
          first_header = b;
          mask_flag = 1'b0;
          length_reg = '0;
          unmask_key = '0;
          remaining = '0;
          mask_index = '0;
          field_count = '0;
          bad_opcode = !opcode_valid(b[3:0]);
          if (last) short_frame();
          else phase = PH_HDR1;
        end
        PH_HDR1: begin
          if (bad_opcode) begin
            phase = last ? PH_HDR0 : PH_DRAIN;
            push_error(ERR_OPCODE);
          end else begin
            mask_flag = b[7];
            len7 = b[6:0];
            if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
              if (last) begin
                short_frame();
              end else begin
                field_count = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                length_reg = '0;
                phase = PH_EXT;
              end
            end else begin
              length_reg = {57'd0, len7};
              length_done(last);
            end
          end
        end
        PH_EXT: begin
          length_reg = {length_reg[55:0], b};
          field_count = field_count - 4'd1;
          if (field_count != 4'd0) begin
            if (last) short_frame();
          end else begin
            length_done(last);
          end
        end
        PH_KEY: begin
          unmask_key = {unmask_key[23:0], b};
          field_count = field_count - 4'd1;
          if (field_count != 4'd0) begin
            if (last) short_frame();
          end else begin
            header_done(last);
          end
        end
        PH_PAY: begin
          remaining = remaining - 64'd1;
          if (remaining != 64'd0 && last) begin
            short_frame();
          end else begin
            sh = 24 - 8 * int'(mask_index);
            kb = unmask_key[sh +: 8];
            mask_index = mask_index + 2'd1;
            done = (remaining == 64'd0);
            if (done) phase = last ? PH_HDR0 : PH_DRAIN;
            push_frame(KIND_PAY, b ^ kb, done);
          end
        end
        default: begin
          if (last) phase = PH_HDR0;
        end
      endcase
    endfunction

    function void report(string field, logic [63:0] want_v, logic [63:0] got_v);
      failures++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
    endfunction

    function void check_word(frame_word_t got);
      frame_word_t want;
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result word, expected none, got kind %0d",
                 $time, got.kind);
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind) report("kind", want.kind, got.kind);
      if (got.payload !== want.payload) report("payload_byte", want.payload, got.payload);
      if (got.fin !== want.fin) report("final_fragment", want.fin, got.fin);
      if (got.rsv !== want.rsv) report("reserved_bits", want.rsv, got.rsv);
      if (got.opcode !== want.opcode) report("frame_opcode", want.opcode, got.opcode);
      if (got.masked !== want.masked) report("masked", want.masked, got.masked);
      if (got.length !== want.length) report("length", want.length, got.length);
      if (got.done !== want.done) report("frame_done", want.done, got.done);
      if (got.err !== want.err) report("error_code", want.err, got.err);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  frame_scoreboard board;
  int burst_left;
  bit steady;
  int hold_asks = 0;
  int holds_done = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  websocket_frame_deframer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  task automatic send_word(logic [7:0] b, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (steady) gap = 0;
      else if ($urandom_range(0, 4) == 0) gap = $urandom_range(4, 12);
      else gap = $urandom_range(0, 3);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.parse_byte(b, last);
    burst_left--;
  endtask

  task automatic send_frame(logic [7:0] hdr0, logic mask, len_form_t form, logic [63:0] len,
                            logic [31:0] key, int cut, int trail);
    logic [7:0] frame_q[$];
    int npay;
    int stop;
    int i;
    frame_q.insert(frame_q.size(), hdr0);
    case (form)
      FORM_7BIT: frame_q.insert(frame_q.size(), {mask, len[6:0]});
      FORM_16BIT: begin
        frame_q.insert(frame_q.size(), {mask, LEN_EXT16});
        frame_q.insert(frame_q.size(), len[15:8]);
        frame_q.insert(frame_q.size(), len[7:0]);
      end
      default: begin
        frame_q.insert(frame_q.size(), {mask, LEN_EXT64});
        for (i = 7; i >= 0; i--) frame_q.insert(frame_q.size(), len[i*8 +: 8]);
      end
    endcase
    if (mask) for (i = 3; i >= 0; i--) frame_q.insert(frame_q.size(), key[i*8 +: 8]);
    npay = (len > 64'd300) ? $urandom_range(0, 40) : int'(len);
    repeat (npay) frame_q.insert(frame_q.size(), 8'($urandom));
    repeat (trail) frame_q.insert(frame_q.size(), 8'($urandom));
    stop = frame_q.size() - 1;
    if (cut == ANY_CUT) stop = $urandom_range(0, stop);
    else if (cut >= 0 && cut < stop) stop = cut;
    for (i = 0; i <= stop; i++) send_word(frame_q[i], i == stop);
  endtask

  task automatic random_frame(bit broken);
    logic [7:0]  hdr0;
    logic [63:0] len;
    len_form_t   form;
    int          pick;
    int          trail;
    hdr0 = 8'($urandom);
    case ($urandom_range(0, 5))
      0: hdr0[3:0] = OP_CONT;
      1: hdr0[3:0] = OP_TEXT;
      2: hdr0[3:0] = OP_BINARY;
      3: hdr0[3:0] = OP_CLOSE;
      4: hdr0[3:0] = OP_PING;
      default: hdr0[3:0] = OP_PONG;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      form = FORM_7BIT;
      len = 64'($urandom_range(0, 20));
    end else if (pick < 75) begin
      form = FORM_7BIT;
      len = 64'($urandom_range(0, 125));
    end else if (pick < 90) begin
      form = FORM_16BIT;
      len = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 300))
                                        : 64'($urandom_range(0, 40));
    end else begin
      form = FORM_64BIT;
      len = 64'($urandom_range(0, 30));
    end
    if (broken && form == FORM_16BIT && $urandom_range(0, 3) == 0)
      len = 64'($urandom_range(0, 65535));
    if (broken && form == FORM_64BIT && $urandom_range(0, 1) == 0) len = {$urandom, $urandom};
    trail = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3);
    send_frame(hdr0, 1'($urandom_range(0, 1)), form, len, $urandom,
               broken ? ANY_CUT : NO_CUT, trail);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // The receiver holds off while a long frame keeps arriving, so the input side backs up.
  task automatic stall_episode();
    hold_asks++;
    steady = 1'b1;
    send_frame({1'b1, 3'd0, OP_BINARY}, 1'b1, FORM_7BIT, 64'd60, $urandom, NO_CUT, 0);
    wait_drain();
    steady = 1'b0;
  endtask

  initial begin : receiver
    rx_mode_t    rx_mode;
    int          rx_span;
    int          hold_left;
    int          rx_cycle;
    frame_word_t got;
    out_tready = 1'b0;
    rx_mode = RX_OPEN;
    rx_span = 0;
    hold_left = 0;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.kind = kind_t'(out_tuser);
        got.payload = out_tdata[7:0];
        got.fin = out_tdata[8];
        got.rsv = out_tdata[11:9];
        got.opcode = out_tdata[15:12];
        got.masked = out_tdata[16];
        got.length = out_tdata[80:17];
        got.done = out_tlast;
        got.err = err_code_t'(out_tdata[81]);
        board.check_word(got);
      end
      rx_cycle++;
      if (rx_span == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_span = $urandom_range(32, 200);
      end else begin
        rx_span--;
      end
      if (hold_left == 0 && holds_done != hold_asks) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN: out_tready <= 1'b1;
          RX_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ((rx_cycle % 7) < 4);
        endcase
      end
    end
  end

  initial begin : stimulus
    int   directed_end;
    int   frames;
    int   pick;
    int   waited;
    int   n;
    int   i;
    logic [7:0] hdr0;
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    burst_left = 0;
    steady = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_frame({1'b1, 3'd0, OP_TEXT}, 1'b0, FORM_7BIT, 64'd5, '0, 0, 0);
    send_frame({1'b0, 3'd0, OP_RESERVED_LO}, 1'b0, FORM_7BIT, 64'd0, '0, 0, 0);
    send_frame({1'b1, 3'd0, OP_RESERVED_HI}, 1'b0, FORM_7BIT, 64'd0, '0, NO_CUT, 1);
    send_frame({1'b1, 3'd0, OP_PING}, 1'b0, FORM_7BIT, 64'd0, '0, NO_CUT, 0);
    send_frame({1'b0, 3'd5, OP_BINARY}, 1'b0, FORM_16BIT, 64'd2, '0, 3, 0);
    send_frame({1'b1, 3'd7, OP_PONG}, 1'b1, FORM_7BIT, 64'd2, 32'hFF00A5C3, NO_CUT, 0);
    send_frame({1'b0, 3'd7, OP_CONT}, 1'b0, FORM_64BIT, 64'hFFFF_FFFF_FFFF_FFFF, '0, 10, 0);
    wait_drain();
    stall_episode();

    directed_end = board.useful_bytes;
    frames = 0;
    while (board.useful_bytes < directed_end + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) steady = !steady;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        random_frame(1'b0);
      end else if (pick < 85) begin
        random_frame(1'b1);
      end else if (pick < 93) begin
        hdr0 = 8'($urandom);
        while (opcode_valid(hdr0[3:0])) hdr0[3:0] = 4'($urandom);
        send_frame(hdr0, 1'($urandom_range(0, 1)), FORM_7BIT, 64'($urandom_range(0, 10)),
                   $urandom, ($urandom_range(0, 1) == 0) ? ANY_CUT : NO_CUT,
                   $urandom_range(0, 2));
      end else begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++)
          send_word(8'($urandom), (i == n - 1) || ($urandom_range(0, 7) == 0));
      end
      frames++;
      if (frames % 40 == 0) stall_episode();
    end
    in_tvalid <= 1'b0;

    waited = 0;
    while (board.pending_results.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_SLACK) @(posedge clk);
    if (board.pending_results.size() != 0) begin
      board.failures += board.pending_results.size();
      $display("%0t: %0d expected result words never arrived",
               $time, board.pending_results.size());
    end
    if (board.failures == 0) begin
      $display("websocket_frame_deframer_top test passed");
    end else begin
      $display("websocket_frame_deframer_top test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("websocket_frame_deframer_top test failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/wsfd_pkg.sv
hdl/wsfd_front.sv
hdl/wsfd_queue.sv
hdl/wsfd_back.sv
hdl/websocket_frame_deframer_top.sv
bench/tb.sv
